### rtl/mpfde_pkg.sv
// Shared constants and types for the page framebuffer draw engine.
package mpfde_pkg;

   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int ADDR_MAX_W     = 13;

   localparam logic [2:0] KIND_CLEAR  = 3'd0;
   localparam logic [2:0] KIND_PIXEL  = 3'd1;
   localparam logic [2:0] KIND_LINE   = 3'd2;
   localparam logic [2:0] KIND_CIRCLE = 3'd3;
   localparam logic [2:0] KIND_DISC   = 3'd4;
   localparam logic [2:0] KIND_READ   = 3'd5;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;

   localparam logic [1:0] OP_SET  = 2'd0;
   localparam logic [1:0] OP_ZERO = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef struct packed {
      logic                  en;
      logic [1:0]            op;
      logic [ADDR_MAX_W-1:0] addr;
      logic [2:0]            bit_sel;
   } store_req_type;

endpackage

### rtl/mpfde_if.sv
// Channel interfaces for commands, results and register writes.
interface mpfde_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] coord_x;
   logic [7:0] coord_y;
   logic [7:0] x_end;
   logic [7:0] radius;
   logic [9:0] read_index;
   modport source (output valid, kind, coord_x, coord_y, x_end, radius, read_index,
                   input ready);
   modport sink (input valid, kind, coord_x, coord_y, x_end, radius, read_index,
                 output ready);
endinterface

interface mpfde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

interface mpfde_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/mpfde_store.sv
// Frame store memory with a read-modify-write unit for setting single pixels.
module mpfde_store
   import mpfde_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH * ((DEF_MAX_HEIGHT + 7) / 8),
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  store_req_type req,
   output logic [7:0]    rd_data,
   output logic          busy
);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_ff;
   logic          pend_ff;
   logic          pend_in;
   logic [AW-1:0] addr_ff;
   logic [7:0]    mask_ff;

   assign pend_in = req.en && (req.op == OP_SET);

   always_ff @(posedge clock) begin
      if (req.en && req.op == OP_ZERO) begin
         mem[req.addr[AW-1:0]] <= 8'd0;
      end else if (pend_ff) begin
         mem[addr_ff] <= rd_ff | mask_ff;
      end
      if (req.en) begin
         rd_ff <= mem[req.addr[AW-1:0]];
      end
      addr_ff <= req.addr[AW-1:0];
      mask_ff <= 8'd1 << req.bit_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   assign rd_data = rd_ff;
   assign busy    = pend_ff;

endmodule

### rtl/mono_page_framebuffer_draw_engine_core.sv
// Top level of the monochrome page framebuffer draw engine.
// After reset the block zeroes the whole store, one byte a cycle (MAX_WIDTH times
// ceil(MAX_HEIGHT/8) bytes, 1024 by default), before it takes the first command.
// A command is taken only while no other is in work; every command returns one
// word. Each drawn pixel that lands in the image is a read-modify-write of one byte,
// and the next pixel waits until that write is done; a disc offset outside the radius
// or a pixel off the image writes nothing. A circle has 8 points per step over about
// 0.7 r steps, a disc (2r+1) squared offsets; a clear zeroes the whole pages in the image.
module mono_page_framebuffer_draw_engine_core
   import mpfde_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   mpfde_req_if.sink   req_port,
   mpfde_rsp_if.source rsp_port,
   mpfde_csr_if.sink   csr_port
);

   localparam int DEPTH = MAX_WIDTH * ((MAX_HEIGHT + 7) / 8);
   localparam int AW    = $clog2(DEPTH);
   localparam logic [ADDR_MAX_W-1:0] DEPTH_C = ADDR_MAX_W'(DEPTH);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CLR   = 4'd2;
   localparam logic [3:0] S_GEN   = 4'd3;
   localparam logic [3:0] S_DISC0 = 4'd4;
   localparam logic [3:0] S_RD    = 4'd5;
   localparam logic [3:0] S_DONE  = 4'd6;

   localparam logic [1:0] M_POINT  = 2'd0;
   localparam logic [1:0] M_LINE   = 2'd1;
   localparam logic [1:0] M_CIRCLE = 2'd2;
   localparam logic [1:0] M_DISC   = 2'd3;

   logic [3:0]  state_ff, state_in;
   logic [7:0]  width_ff, width_in;
   logic [6:0]  height_ff, height_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [7:0]  data_ff, data_in;
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [7:0]  cur_ff, cur_in, hi_ff, hi_in;
   logic [7:0]  r_ff, r_in;
   logic signed [9:0]  x_ff, x_in, y_ff, y_in;
   logic signed [11:0] err_ff, err_in;
   logic [2:0]  pt_ff, pt_in;
   logic signed [8:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [16:0] dxsq_ff, dxsq_in, dysq_ff, dysq_in;
   logic [15:0] rr_ff, rr_in;
   logic [ADDR_MAX_W-1:0] cnt_ff, cnt_in, lim_ff, lim_in;

   logic [7:0]  w_eff, h_eff;
   logic [ADDR_MAX_W-1:0] clr_lim;
   logic [7:0]  px, py;
   logic        pok, plast;
   logic [ADDR_MAX_W-1:0] pidx;
   logic        pin;
   logic [7:0]  xb, yb;
   logic signed [11:0] yn12, xn12, err_nx;
   logic signed [9:0]  x_nx;
   logic signed [8:0]  r_s;
   logic signed [17:0] dx_inc, dy_inc;
   logic        req_acc;
   logic        done_go;
   store_req_type sreq;
   logic [7:0]  st_rdata;
   logic        st_busy;

   mpfde_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (sreq),
      .rd_data (st_rdata),
      .busy    (st_busy)
   );

   assign w_eff = (width_ff > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : width_ff;
   assign h_eff = ({1'b0, height_ff} > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : {1'b0, height_ff};

   always_comb begin
      clr_lim = ADDR_MAX_W'(w_eff) * ADDR_MAX_W'(h_eff[7:3]);
      if (clr_lim > DEPTH_C) begin
         clr_lim = DEPTH_C;
      end
   end

   assign xb     = x_ff[7:0];
   assign yb     = y_ff[7:0];
   assign yn12   = 12'(y_ff) + 12'sd1;
   assign r_s    = $signed({1'b0, r_ff});
   assign dx_inc = {{8{dx_ff[8]}}, dx_ff, 1'b1};
   assign dy_inc = {{8{dy_ff[8]}}, dy_ff, 1'b1};

   always_comb begin
      if (err_ff < 0) begin
         x_nx   = x_ff;
         err_nx = err_ff + (yn12 <<< 1) + 12'sd1;
      end else begin
         x_nx   = x_ff - 10'sd1;
         err_nx = err_ff + ((yn12 - 12'(x_nx)) <<< 1) + 12'sd1;
      end
      xn12 = 12'(x_nx);
   end

   always_comb begin
      px    = cx_ff;
      py    = cy_ff;
      pok   = 1'b1;
      plast = 1'b1;
      case (mode_ff)
         M_POINT: begin
            plast = 1'b1;
         end
         M_LINE: begin
            px    = cur_ff;
            plast = (cur_ff == hi_ff);
         end
         M_CIRCLE: begin
            case (pt_ff)
               3'd0: begin px = cx_ff + xb; py = cy_ff + yb; end
               3'd1: begin px = cx_ff + yb; py = cy_ff + xb; end
               3'd2: begin px = cx_ff - yb; py = cy_ff + xb; end
               3'd3: begin px = cx_ff - xb; py = cy_ff + yb; end
               3'd4: begin px = cx_ff - xb; py = cy_ff - yb; end
               3'd5: begin px = cx_ff - yb; py = cy_ff - xb; end
               3'd6: begin px = cx_ff + yb; py = cy_ff - xb; end
               default: begin px = cx_ff + xb; py = cy_ff - yb; end
            endcase
            plast = (pt_ff == 3'd7) && (xn12 < yn12);
         end
         default: begin
            px    = cx_ff + dx_ff[7:0];
            py    = cy_ff + dy_ff[7:0];
            pok   = ({1'b0, dxsq_ff} + {1'b0, dysq_ff}) <= {2'b0, rr_ff};
            plast = (dx_ff == r_s) && (dy_ff == r_s);
         end
      endcase
   end

   assign pidx = ADDR_MAX_W'(py[7:3]) * ADDR_MAX_W'(w_eff) + ADDR_MAX_W'(px);
   assign pin  = pok && (px < w_eff) && (py < h_eff) && (pidx < DEPTH_C);

   assign req_acc  = req_port.valid && req_port.ready;
   assign done_go  = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == S_IDLE);
   assign csr_port.ready = 1'b1;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.read_data = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_data_in  = rsp_data_ff;
      data_in      = data_ff;
      mode_in      = mode_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cur_in       = cur_ff;
      hi_in        = hi_ff;
      r_in         = r_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      err_in       = err_ff;
      pt_in        = pt_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dxsq_in      = dxsq_ff;
      dysq_in      = dysq_ff;
      rr_in        = rr_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      sreq         = '0;

      if (csr_port.valid) begin
         if (csr_port.index == REG_WIDTH) begin
            width_in = csr_port.data;
         end else if (csr_port.index == REG_HEIGHT) begin
            height_in = csr_port.data[6:0];
         end
      end

      case (state_ff)
         S_INIT: begin
            sreq.en   = 1'b1;
            sreq.op   = OP_ZERO;
            sreq.addr = cnt_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == DEPTH_C - 1'b1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               data_in = 8'd0;
               cx_in   = req_port.coord_x;
               cy_in   = req_port.coord_y;
               r_in    = req_port.radius;
               case (req_port.kind)
                  KIND_CLEAR: begin
                     cnt_in   = '0;
                     lim_in   = clr_lim;
                     state_in = (clr_lim == '0) ? S_DONE : S_CLR;
                  end
                  KIND_PIXEL: begin
                     mode_in  = M_POINT;
                     state_in = S_GEN;
                  end
                  KIND_LINE: begin
                     mode_in = M_LINE;
                     if (req_port.coord_x > req_port.x_end) begin
                        cur_in = req_port.x_end;
                        hi_in  = req_port.coord_x;
                     end else begin
                        cur_in = req_port.coord_x;
                        hi_in  = req_port.x_end;
                     end
                     state_in = S_GEN;
                  end
                  KIND_CIRCLE: begin
                     mode_in  = M_CIRCLE;
                     x_in     = $signed({2'b0, req_port.radius});
                     y_in     = '0;
                     err_in   = 12'sd1 - $signed({4'b0, req_port.radius});
                     pt_in    = '0;
                     state_in = S_GEN;
                  end
                  KIND_DISC: begin
                     mode_in  = M_DISC;
                     state_in = S_DISC0;
                  end
                  KIND_READ: begin
                     if (ADDR_MAX_W'(req_port.read_index) < DEPTH_C) begin
                        sreq.en   = 1'b1;
                        sreq.op   = OP_READ;
                        sreq.addr = ADDR_MAX_W'(req_port.read_index);
                        state_in  = S_RD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CLR: begin
            sreq.en   = 1'b1;
            sreq.op   = OP_ZERO;
            sreq.addr = cnt_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 == lim_ff) begin
               state_in = S_DONE;
            end
         end
         S_DISC0: begin
            rr_in    = 16'(r_ff) * 16'(r_ff);
            dxsq_in  = {1'b0, rr_in};
            dysq_in  = {1'b0, rr_in};
            dx_in    = -r_s;
            dy_in    = -r_s;
            state_in = S_GEN;
         end
         S_GEN: begin
            if (!st_busy) begin
               if (pin) begin
                  sreq.en      = 1'b1;
                  sreq.op      = OP_SET;
                  sreq.addr    = pidx;
                  sreq.bit_sel = py[2:0];
               end
               if (plast) begin
                  state_in = S_DONE;
               end
               case (mode_ff)
                  M_LINE: begin
                     cur_in = cur_ff + 8'd1;
                  end
                  M_CIRCLE: begin
                     pt_in = pt_ff + 3'd1;
                     if (pt_ff == 3'd7) begin
                        y_in   = y_ff + 10'sd1;
                        x_in   = x_nx;
                        err_in = err_nx;
                     end
                  end
                  M_DISC: begin
                     if (dx_ff == r_s) begin
                        dx_in   = -r_s;
                        dxsq_in = {1'b0, rr_ff};
                        dy_in   = dy_ff + 9'sd1;
                        dysq_in = 17'($signed({1'b0, dysq_ff}) + dy_inc);
                     end else begin
                        dx_in   = dx_ff + 9'sd1;
                        dxsq_in = 17'($signed({1'b0, dxsq_ff}) + dx_inc);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            data_in  = st_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (done_go) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         width_ff     <= 8'd128;
         height_ff    <= 7'd64;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      data_ff     <= data_in;
      mode_ff     <= mode_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cur_ff      <= cur_in;
      hi_ff       <= hi_in;
      r_ff        <= r_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      err_ff      <= err_in;
      pt_ff       <= pt_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dxsq_ff     <= dxsq_in;
      dysq_ff     <= dysq_in;
      rr_ff       <= rr_in;
      lim_ff      <= lim_in;
   end

endmodule

### rtl/mpfde_checker.sv
// Port-level checks for the draw engine, bound to the top level.
module mpfde_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data,
   input logic       csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result word dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("Result word changed while stalled.");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Second command taken while one is in work.");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> csr_ready)
      else $error("Register write port not ready.");

endmodule

bind mono_page_framebuffer_draw_engine_core mpfde_checker u_mpfde_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_data  (rsp_port.read_data),
   .csr_ready (csr_port.ready)
);
